### hdl/ipfl_pkg.sv
// Shared constants and control types for the index pool free-list allocator.
`timescale 1ns / 1ps

package ipfl_pkg;

  localparam int POOL_DEPTH_DEF = 1024;

  localparam int IDX_W = 10;
  localparam int CNT_W = 11;
  localparam int ST_W  = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic accept;
    logic commit;
  } ipfl_cmd_t;

  typedef struct packed {
    logic out_stall;
  } ipfl_sts_t;

endpackage

### hdl/ipfl_if.sv
// Handshake channel interfaces for request, result and configuration beats.
`timescale 1ns / 1ps

interface ipfl_in_if import ipfl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [IDX_W-1:0] slot_index;

  modport source (output valid, output func, output slot_index, input ready);
  modport sink   (input valid, input func, input slot_index, output ready);
endinterface

interface ipfl_out_if import ipfl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] granted_index;
  logic [ST_W-1:0]  status;
  logic [CNT_W-1:0] live_count;

  modport source (output valid, output granted_index, output status, output live_count,
                  input ready);
  modport sink   (input valid, input granted_index, input status, input live_count,
                  output ready);
endinterface

interface ipfl_cfg_if import ipfl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/ipfl_ctrl.sv
// Controller state machine: accept one request beat, then commit it to the result register.
`timescale 1ns / 1ps

module ipfl_ctrl import ipfl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ipfl_sts_t sts,
  output ipfl_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;

  always_comb begin
    in_ready   = (state_r == S_IDLE);
    cmd.accept = in_valid && in_ready;
    cmd.commit = (state_r == S_EXEC) && !sts.out_stall;
    state_nxt  = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/ipfl_dp.sv
// Datapath: link and alive stores, head/bump/count registers, capacity and result register.
`timescale 1ns / 1ps

module ipfl_dp import ipfl_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ipfl_cmd_t        cmd,
  output ipfl_sts_t        sts,
  input  logic             in_func,
  input  logic [IDX_W-1:0] in_slot_index,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [IDX_W-1:0] out_granted_index,
  output logic [ST_W-1:0]  out_status,
  output logic [CNT_W-1:0] out_live_count
);

  localparam int IW = $clog2(POOL_DEPTH);
  localparam int HW = $clog2(POOL_DEPTH + 1);
  localparam int CW = (HW > CNT_W) ? HW : CNT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);

  logic [HW-1:0]    link_mem [POOL_DEPTH];
  logic             alive_mem [POOL_DEPTH];
  logic [HW-1:0]    link_rd_r;
  logic             alive_rd_r;

  logic             func_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] cap_r;
  logic [HW-1:0]    head_r, head_nxt;
  logic [HW-1:0]    bump_r, bump_nxt;
  logic [HW-1:0]    used_r, used_nxt;

  logic             out_valid_r;
  logic [IDX_W-1:0] grant_r, grant_nxt;
  logic [ST_W-1:0]  status_r, status_nxt;
  logic [CNT_W-1:0] live_r;

  logic [CW-1:0]    head_ext, bump_ext, used_ext, used_nxt_ext;
  logic [CW-1:0]    idx_ext, in_idx_ext, cap_ext, eff_cap;
  logic             full, bad;
  logic             link_we, alive_we, alive_wdata;
  logic [IW-1:0]    alive_waddr;

  assign head_ext     = CW'(head_r);
  assign bump_ext     = CW'(bump_r);
  assign used_ext     = CW'(used_r);
  assign used_nxt_ext = CW'(used_nxt);
  assign idx_ext      = CW'(idx_r);
  assign in_idx_ext   = CW'(in_slot_index);
  assign cap_ext      = CW'(cap_r);

  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > DEPTH_C) begin
      eff_cap = DEPTH_C;
    end else begin
      eff_cap = cap_ext;
    end
  end

  always_comb begin
    head_nxt    = head_r;
    bump_nxt    = bump_r;
    used_nxt    = used_r;
    grant_nxt   = '0;
    status_nxt  = ST_OK;
    full        = 1'b0;
    bad         = 1'b0;
    link_we     = 1'b0;
    alive_we    = 1'b0;
    alive_wdata = 1'b0;
    alive_waddr = head_r[IW-1:0];
    if (func_r == FUNC_ALLOC) begin
      full = (used_ext >= eff_cap) || (head_ext >= DEPTH_C);
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        if (head_r == bump_r) begin
          bump_nxt = bump_r + HW'(1);
          head_nxt = head_r + HW'(1);
        end else begin
          head_nxt = link_rd_r;
        end
        used_nxt    = used_r + HW'(1);
        alive_we    = cmd.commit;
        alive_wdata = 1'b1;
        grant_nxt   = head_ext[IDX_W-1:0];
      end
    end else begin
      bad = (idx_r == '0) || (idx_ext >= bump_ext) || (idx_ext >= DEPTH_C) || !alive_rd_r;
      if (bad) begin
        status_nxt = ST_BAD;
      end else begin
        link_we     = cmd.commit;
        alive_we    = cmd.commit;
        alive_wdata = 1'b0;
        alive_waddr = idx_ext[IW-1:0];
        head_nxt    = idx_ext[HW-1:0];
        used_nxt    = used_r - HW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[idx_ext[IW-1:0]] <= head_r;
    end
    if (cmd.accept) begin
      link_rd_r <= link_mem[head_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (alive_we) begin
      alive_mem[alive_waddr] <= alive_wdata;
    end
    if (cmd.accept) begin
      alive_rd_r <= alive_mem[in_idx_ext[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_func;
      idx_r  <= in_slot_index;
    end
    if (cmd.commit) begin
      grant_r  <= grant_nxt;
      status_r <= status_nxt;
      live_r   <= used_nxt_ext[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      head_r      <= HW'(1);
      bump_r      <= HW'(1);
      used_r      <= HW'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      if (cmd.commit) begin
        head_r      <= head_nxt;
        bump_r      <= bump_nxt;
        used_r      <= used_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_stall     = out_valid_r && !out_ready;
  assign out_valid         = out_valid_r;
  assign out_granted_index = grant_r;
  assign out_status        = status_r;
  assign out_live_count    = live_r;

endmodule

### hdl/index_pool_free_list_allocator_top.sv
// Top level of the index pool free-list allocator: controller, datapath and channel ports.
// A request is accepted in the idle state, then executed on the registered link/alive
// memory read; the result register loads when the execute step commits, and a stalled
// result register holds the execute step. No new request is accepted until it commits.
// Reset (rst_n, synchronous, active low): head, bump top and live count return to one,
// capacity to 1024; alive marks need no clearing pass, only slots below the bump top are read.
`timescale 1ns / 1ps

module index_pool_free_list_allocator_top import ipfl_pkg::*; #(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ipfl_in_if.sink    in_ch,
  ipfl_out_if.source out_ch,
  ipfl_cfg_if.sink   cfg_ch
);

  ipfl_cmd_t cmd;
  ipfl_sts_t sts;
  logic      in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  ipfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ipfl_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_ch.func),
    .in_slot_index     (in_ch.slot_index),
    .cfg_we            (cfg_ch.valid),
    .cfg_data          (cfg_ch.data),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_granted_index (out_ch.granted_index),
    .out_status        (out_ch.status),
    .out_live_count    (out_ch.live_count)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !in_ch.ready)
    else $error("request accepted while another is in flight");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.commit))
    else $error("result beat appeared without a commit");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status == ST_OK || out_ch.status == ST_FULL ||
                      out_ch.status == ST_BAD))
    else $error("undefined status code");

  a_refused_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.granted_index == '0))
    else $error("refused or bad request carries a granted index");

endmodule

### test/tb_top.sv
// Self-checking testbench for the index pool free-list allocator with a built-in slot predictor.
`timescale 1ns / 1ps

module tb_top;
  import ipfl_pkg::*;

  localparam int DEPTH        = POOL_DEPTH_DEF;
  localparam int QUIET_LIMIT  = 1000;
  localparam int SETTLE_TICKS = 4;

  typedef struct packed {
    logic [IDX_W-1:0] granted;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] live;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n;

  ipfl_in_if  in_ch();
  ipfl_out_if out_ch();
  ipfl_cfg_if cfg_ch();

  index_pool_free_list_allocator_top #(.POOL_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Slot predictor state
  logic [CNT_W-1:0] cap_reg;
  logic [CNT_W-1:0] link_mem [DEPTH];
  bit               alive_mem [DEPTH];
  logic [CNT_W-1:0] head_slot;
  logic [CNT_W-1:0] bump_slot;
  logic [CNT_W-1:0] live_slots;
  int               held_slots[$];

  grant_t expected_grants[$];
  int     mismatches = 0;
  int     quiet_cycles = 0;
  bit     no_gaps = 1'b0;

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  function automatic logic [CNT_W-1:0] usable_capacity();
    logic [CNT_W-1:0] c;
    c = cap_reg;
    if (c < 1) c = CNT_W'(1);
    if (c > DEPTH) c = CNT_W'(DEPTH);
    return c;
  endfunction

  function automatic void predict_pool_op(input logic f, input logic [IDX_W-1:0] idx);
    grant_t g;
    int     slot;
    g.granted = '0;
    g.status  = ST_OK;
    if (f == FUNC_ALLOC) begin
      if (live_slots >= usable_capacity() || head_slot >= DEPTH) begin
        g.status = ST_FULL;
      end else begin
        slot = int'(head_slot);
        if (head_slot == bump_slot) begin
          bump_slot++;
          head_slot++;
        end else begin
          head_slot = link_mem[slot];
        end
        live_slots++;
        alive_mem[slot] = 1'b1;
        held_slots.push_back(slot);
        g.granted = slot[IDX_W-1:0];
      end
    end else begin
      if (idx == 0 || idx >= bump_slot || !alive_mem[idx]) begin
        g.status = ST_BAD;
      end else begin
        link_mem[idx]  = head_slot;
        alive_mem[idx] = 1'b0;
        head_slot      = CNT_W'(idx);
        live_slots--;
        for (int k = 0; k < held_slots.size(); k++) begin
          if (held_slots[k] == idx) begin
            held_slots.delete(k);
            break;
          end
        end
      end
    end
    g.live = live_slots;
    expected_grants.push_back(g);
  endfunction

  task automatic issue_request(input logic f, input logic [IDX_W-1:0] idx);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.slot_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    predict_pool_op(f, idx);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cap_reg = value;
  endtask

  task automatic alloc_one();
    logic [IDX_W-1:0] junk;
    junk = IDX_W'($urandom);
    issue_request(FUNC_ALLOC, junk);
  endtask

  task automatic test_alloc_and_free();
    repeat (3) alloc_one();
    issue_request(FUNC_FREE, 10'd2);
    issue_request(FUNC_FREE, 10'd2);
    issue_request(FUNC_FREE, 10'd0);
    issue_request(FUNC_FREE, 10'd4);
    issue_request(FUNC_FREE, 10'd1023);
    alloc_one();
    issue_request(FUNC_FREE, 10'd1);
    issue_request(FUNC_FREE, 10'd3);
    repeat (3) alloc_one();
  endtask

  task automatic test_capacity_limits();
    write_capacity(11'd0);
    alloc_one();
    write_capacity(11'd1);
    alloc_one();
    write_capacity(11'd2);
    alloc_one();
    for (int s = 1; s <= 4; s++) issue_request(FUNC_FREE, s[IDX_W-1:0]);
    alloc_one();
    alloc_one();
    write_capacity(11'd2047);
    alloc_one();
  endtask

  task automatic run_traffic(input logic [CNT_W-1:0] cap, input int count, input int alloc_pct);
    logic [IDX_W-1:0] idx;
    write_capacity(cap);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < alloc_pct) begin
        alloc_one();
      end else if (held_slots.size() > 0 && $urandom_range(0, 99) < 80) begin
        issue_request(FUNC_FREE,
                      IDX_W'(held_slots[$urandom_range(0, held_slots.size() - 1)]));
      end else begin
        case ($urandom_range(0, 3))
          0: idx = '0;
          1: idx = bump_slot[IDX_W-1:0];
          2: idx = 10'd1023;
          default: idx = IDX_W'($urandom);
        endcase
        issue_request(FUNC_FREE, idx);
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_traffic(11'd6, 150, 50);
    run_traffic(11'd200, 250, 70);
    run_traffic(11'd2047, 850, 92);
    run_traffic(11'd1024, 120, 15);
    run_traffic(11'd3, 60, 30);
  endtask

  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin : result_check
    grant_t g;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_grants.size() == 0) begin
        flag_mismatch("result beat with nothing outstanding");
      end else begin
        g = expected_grants.pop_front();
        if (out_ch.granted_index !== g.granted)
          flag_mismatch($sformatf("granted_index %0d, want %0d", out_ch.granted_index, g.granted));
        if (out_ch.status !== g.status)
          flag_mismatch($sformatf("status %0d, want %0d", out_ch.status, g.status));
        if (out_ch.live_count !== g.live)
          flag_mismatch($sformatf("live_count %0d, want %0d", out_ch.live_count, g.live));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_ALLOC;
    in_ch.slot_index <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.data      <= '0;
    cap_reg    = CAP_RESET;
    head_slot  = CNT_W'(1);
    bump_slot  = CNT_W'(1);
    live_slots = CNT_W'(1);
    foreach (alive_mem[k]) alive_mem[k] = 1'b0;
    foreach (link_mem[k]) link_mem[k] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_alloc_and_free();
    test_capacity_limits();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
